@@ sv/oneshot_countdown_timer_bank_unit_macros.svh @@
// Assertion macros used by the checker file of the timer bank.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ONESHOT_COUNTDOWN_TIMER_BANK_UNIT_MACROS_SVH
`define ONESHOT_COUNTDOWN_TIMER_BANK_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define OTB_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("timer bank assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define OTB_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("timer bank assertion failed");

`endif

@@ sv/otb_pkg.sv @@
// Package for the one-shot countdown timer bank: sizes, codes and types.
// Used by every module of the bank; depends on nothing.
package otb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam logic [31:0] IDLE_MARK = 32'hffff_ffff;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_APPLY,
        ST_REPORT
    } state_t;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_TICK,
        DP_APPLY,
        DP_REPORT
    } dp_mode_t;

    typedef struct packed {
        dp_mode_t               mode;
        logic [TIMER_IDX_W-1:0] addr;
        cmd_t                   cmd;
        logic [31:0]            value;
        logic                   index_ok;
        logic                   clear_mask;
    } ctrl_t;

endpackage

@@ sv/otb_datapath.sv @@
// Timer state storage and the shared 32-bit subtractor of the timer bank.
// Depends on otb_pkg; driven one timer per cycle by otb_seq.
module otb_datapath
    import otb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output logic [15:0] elapsed_count,
    output logic        running,
    output logic        is_done,
    output logic [7:0]  expired_mask
);

    logic [31:0] cd_reg   [TIMER_COUNT];
    logic [31:0] rl_reg   [TIMER_COUNT];
    logic        run_reg  [TIMER_COUNT];
    logic        done_reg [TIMER_COUNT];

    logic [31:0] rd_cd;
    logic [31:0] rd_rl;
    logic        rd_run;
    logic        rd_done;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] diff;

    logic        wr_en;
    logic [31:0] cd_next;
    logic [31:0] rl_next;
    logic        run_next;
    logic        done_next;

    logic [7:0]  mask_reg;
    logic [7:0]  mask_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic        running_out_reg;
    logic        running_out_next;
    logic        done_out_reg;
    logic        done_out_next;
    logic [7:0]  expired_reg;
    logic [7:0]  expired_next;

    // Read the addressed timer and run the shared subtractor
    always_comb
    begin
        rd_cd   = cd_reg[ctrl.addr];
        rd_rl   = rl_reg[ctrl.addr];
        rd_run  = run_reg[ctrl.addr];
        rd_done = done_reg[ctrl.addr];
        if (ctrl.mode == DP_TICK)
        begin
            op_a = rd_cd;
            op_b = 32'd1;
        end
        else
        begin
            op_a = rd_rl;
            op_b = rd_cd;
        end
        diff = op_a - op_b;
    end

    // Work out the write-back and the result for the current step
    always_comb
    begin
        wr_en            = 1'b0;
        cd_next          = rd_cd;
        rl_next          = rd_rl;
        run_next         = rd_run;
        done_next        = rd_done;
        mask_next        = ctrl.clear_mask ? 8'd0 : mask_reg;
        elapsed_next     = elapsed_reg;
        running_out_next = running_out_reg;
        done_out_next    = done_out_reg;
        expired_next     = expired_reg;
        unique case (ctrl.mode)
            DP_TICK:
            begin
                if (rd_run && (rd_cd != 32'd0) && (rd_cd != IDLE_MARK))
                begin
                    wr_en = 1'b1;
                    if (diff == 32'd0)
                    begin
                        cd_next   = IDLE_MARK;
                        run_next  = 1'b0;
                        done_next = 1'b1;
                        mask_next = mask_reg | (8'd1 << ctrl.addr);
                    end
                    else
                    begin
                        cd_next = diff;
                    end
                end
            end
            DP_APPLY:
            begin
                if (ctrl.index_ok)
                begin
                    unique case (ctrl.cmd)
                        CMD_CLEAR:
                        begin
                            wr_en     = 1'b1;
                            cd_next   = IDLE_MARK;
                            rl_next   = 32'd0;
                            run_next  = 1'b0;
                            done_next = 1'b0;
                        end
                        CMD_LOAD:
                        begin
                            wr_en     = 1'b1;
                            rl_next   = ctrl.value;
                            run_next  = 1'b0;
                            done_next = 1'b0;
                        end
                        CMD_START:
                        begin
                            wr_en     = 1'b1;
                            cd_next   = rd_rl;
                            run_next  = 1'b1;
                            done_next = 1'b0;
                        end
                        CMD_STOP:
                        begin
                            wr_en    = 1'b1;
                            cd_next  = IDLE_MARK;
                            run_next = 1'b0;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            DP_REPORT:
            begin
                expired_next = (ctrl.cmd == CMD_TICK) ? mask_reg : 8'd0;
                if (ctrl.index_ok)
                begin
                    elapsed_next     = diff[15:0];
                    running_out_next = rd_run;
                    done_out_next    = rd_done;
                    // Read status drops done after reporting it
                    if (ctrl.cmd == CMD_READ)
                    begin
                        wr_en     = 1'b1;
                        done_next = 1'b0;
                    end
                end
                else
                begin
                    elapsed_next     = 16'd0;
                    running_out_next = 1'b0;
                    done_out_next    = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Timer state, idle mark after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                cd_reg[i]   <= IDLE_MARK;
                rl_reg[i]   <= 32'd0;
                run_reg[i]  <= 1'b0;
                done_reg[i] <= 1'b0;
            end
            mask_reg <= 8'd0;
        end
        else
        begin
            if (wr_en)
            begin
                cd_reg[ctrl.addr]   <= cd_next;
                rl_reg[ctrl.addr]   <= rl_next;
                run_reg[ctrl.addr]  <= run_next;
                done_reg[ctrl.addr] <= done_next;
            end
            mask_reg <= mask_next;
        end
    end

    // Result payload, held while the transfer is pending
    always_ff @(posedge clk)
    begin
        elapsed_reg     <= elapsed_next;
        running_out_reg <= running_out_next;
        done_out_reg    <= done_out_next;
        expired_reg     <= expired_next;
    end

    assign elapsed_count = elapsed_reg;
    assign running       = running_out_reg;
    assign is_done       = done_out_reg;
    assign expired_mask  = expired_reg;

endmodule

@@ sv/otb_seq.sv @@
// Sequencer of the timer bank: command capture, timer sweep and result handshake.
// Depends on otb_pkg; steers otb_datapath through a ctrl_t bundle.
module otb_seq
    import otb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  cmd,
    input  logic [2:0]  timer_index,
    input  logic [31:0] reload_value,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output ctrl_t       ctrl
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [TIMER_IDX_W-1:0] sweep_reg;
    logic [TIMER_IDX_W-1:0] sweep_next;
    cmd_t                   cmd_reg;
    logic [TIMER_IDX_W-1:0] idx_reg;
    logic [31:0]            value_reg;
    logic                   ok_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;

    logic                   accept;
    logic                   sweep_last;
    logic                   report_go;

    assign accept     = cmd_valid && cmd_ready;
    assign sweep_last = (sweep_reg == TIMER_IDX_W'(TIMER_COUNT - 1));
    assign report_go  = (state_reg == ST_REPORT) && (!rsp_valid_reg || rsp_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sweep_next = '0;
                    state_next = (cmd_t'(cmd) == CMD_TICK) ? ST_TICK : ST_APPLY;
                end
            end
            ST_TICK:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (report_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        cmd_ready       = (state_reg == ST_IDLE);
        ctrl.cmd        = cmd_reg;
        ctrl.value      = value_reg;
        ctrl.index_ok   = ok_reg;
        ctrl.clear_mask = accept;
        ctrl.addr       = idx_reg;
        ctrl.mode       = DP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.mode = DP_NONE;
            end
            ST_TICK:
            begin
                ctrl.mode = DP_TICK;
                ctrl.addr = sweep_reg;
            end
            ST_APPLY:
            begin
                ctrl.mode = DP_APPLY;
            end
            ST_REPORT:
            begin
                ctrl.mode = report_go ? DP_REPORT : DP_NONE;
            end
            default:
            begin
                ctrl.mode = DP_NONE;
            end
        endcase
        // Raise valid on a fresh result, drop it once the transfer completes
        if (report_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold the accepted command for the whole item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(cmd);
            idx_reg   <= TIMER_IDX_W'(timer_index);
            value_reg <= reload_value;
            ok_reg    <= (32'(timer_index) < TIMER_COUNT);
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ sv/oneshot_countdown_timer_bank_unit.sv @@
// Top level of the one-shot countdown timer bank.
// Depends on otb_pkg, otb_seq and otb_datapath.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   command | cmd_valid / cmd_ready | cmd, timer_index, reload_value
//   result  | rsp_valid / rsp_ready | elapsed_count, running, is_done, expired_mask
//
// A tick walks the timers through one shared subtractor, one timer a cycle, and then
// goes through the update and report steps before the next cmd_ready; every other
// command goes through capture, update and report.
// Reset clears all timers to the idle mark at once; no clearing pass follows.
// The result sits in an output register; a stalled result holds the block only
// when the next result is ready to be written.
module oneshot_countdown_timer_bank_unit
    import otb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  cmd,
    input  logic [2:0]  timer_index,
    input  logic [31:0] reload_value,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [15:0] elapsed_count,
    output logic        running,
    output logic        is_done,
    output logic [7:0]  expired_mask
);

    ctrl_t ctrl;

    otb_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .timer_index  (timer_index),
        .reload_value (reload_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .ctrl         (ctrl)
    );

    otb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .elapsed_count (elapsed_count),
        .running       (running),
        .is_done       (is_done),
        .expired_mask  (expired_mask)
    );

endmodule

@@ sv/otb_checker.sv @@
// Port-level checks of the timer bank and the bind that attaches them.
// Depends on oneshot_countdown_timer_bank_unit_macros.svh.
`include "oneshot_countdown_timer_bank_unit_macros.svh"

module otb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [15:0] elapsed_count,
    input logic        running,
    input logic        is_done,
    input logic [7:0]  expired_mask
);

    logic [25:0] rsp_payload;

    // Gather the result fields into one word
    assign rsp_payload = {elapsed_count, running, is_done, expired_mask};

    // Stalled result holds its payload
    `OTB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // Busy on the cycle after a command transfer
    `OTB_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

    // A new result comes only out of a busy cycle
    `OTB_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), $past(!cmd_ready))

endmodule

bind oneshot_countdown_timer_bank_unit otb_checker u_otb_checker (.*);

@@ bench/oneshot_countdown_timer_bank_unit_tb.sv @@
// Self-checking bench for the one-shot countdown timer bank: queued commands,
// a clocked driver and monitor, and a cycle-free model of all eight timers.
// Depends on otb_pkg and oneshot_countdown_timer_bank_unit.
`timescale 1ns / 1ps

module oneshot_countdown_timer_bank_unit_tb
    import otb_pkg::*;
;

    // Opcodes the bank does not define; they must only report status
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 2 * (TIMER_COUNT + 3);
    localparam int unsigned PRINT_LIMIT  = 100;

    typedef struct {
        logic [2:0]  op;
        logic [2:0]  idx;
        logic [31:0] value;
    } timer_cmd_t;

    typedef struct {
        logic [15:0] elapsed;
        logic        running;
        logic        done;
        logic [7:0]  fired;
    } timer_status_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [2:0]  cmd = '0;
    logic [2:0]  timer_index = '0;
    logic [31:0] reload_value = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    logic [15:0] elapsed_count;
    logic        running;
    logic        is_done;
    logic [7:0]  expired_mask;

    // Model copy of the timer state
    logic [31:0] count_model  [TIMER_COUNT];
    logic [31:0] reload_model [TIMER_COUNT];
    logic        run_model    [TIMER_COUNT];
    logic        done_model   [TIMER_COUNT];

    timer_cmd_t    cmd_backlog[$];
    timer_status_t status_due[$];
    timer_cmd_t    held_cmd;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned result_count = 0;

    oneshot_countdown_timer_bank_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .timer_index   (timer_index),
        .reload_value  (reload_value),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .elapsed_count (elapsed_count),
        .running       (running),
        .is_done       (is_done),
        .expired_mask  (expired_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the model and return the status it reports
    function automatic timer_status_t apply_command(input timer_cmd_t item);
        timer_status_t st;
        logic [31:0]   diff;
        int unsigned   t;
        st = '{elapsed: '0, running: 1'b0, done: 1'b0, fired: '0};
        if (item.op == CMD_TICK)
        begin
            for (t = 0; t < TIMER_COUNT; t++)
            begin
                if (run_model[t] && count_model[t] != 32'd0 && count_model[t] != IDLE_MARK)
                begin
                    count_model[t] = count_model[t] - 32'd1;
                    if (count_model[t] == 32'd0)
                    begin
                        done_model[t]  = 1'b1;
                        run_model[t]   = 1'b0;
                        count_model[t] = IDLE_MARK;
                        if (t < 8)
                            st.fired[t] = 1'b1;
                    end
                end
            end
        end
        if (item.idx < TIMER_COUNT)
        begin
            case (item.op)
                CMD_CLEAR:
                begin
                    count_model[item.idx]  = IDLE_MARK;
                    reload_model[item.idx] = 32'd0;
                    run_model[item.idx]    = 1'b0;
                    done_model[item.idx]   = 1'b0;
                end
                CMD_LOAD:
                begin
                    reload_model[item.idx] = item.value;
                    run_model[item.idx]    = 1'b0;
                    done_model[item.idx]   = 1'b0;
                end
                CMD_START:
                begin
                    count_model[item.idx] = reload_model[item.idx];
                    run_model[item.idx]   = 1'b1;
                    done_model[item.idx]  = 1'b0;
                end
                CMD_STOP:
                begin
                    count_model[item.idx] = IDLE_MARK;
                    run_model[item.idx]   = 1'b0;
                end
                default:
                begin
                end
            endcase
            diff       = reload_model[item.idx] - count_model[item.idx];
            st.elapsed = diff[15:0];
            st.running = run_model[item.idx];
            st.done    = done_model[item.idx];
            if (item.op == CMD_READ)
                done_model[item.idx] = 1'b0;
        end
        return st;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic [2:0] idx,
                             input logic [31:0] value);
        cmd_backlog.push_back('{op: op, idx: idx, value: value});
    endtask

    // Mostly arm-and-run sequences with random content, plus clears, starts, reads and noise
    task automatic queue_random_batch(input int unsigned target);
        int unsigned queued;
        int unsigned pick;
        int unsigned run_len;
        int unsigned k;
        logic [2:0]  t;
        logic [31:0] v;
        queued = 0;
        while (queued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                t    = 3'($urandom_range(0, 7));
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    v = $urandom_range(1, 12);
                else if (pick == 7)
                    v = ($urandom_range(0, 1) != 0) ? 32'd0 : IDLE_MARK;
                else
                    v = $urandom;
                queue_cmd(CMD_LOAD, t, v);
                queue_cmd(CMD_START, t, $urandom);
                queued += 2;
                run_len = $urandom_range(1, 14);
                for (k = 0; k < run_len; k++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)
                        queue_cmd(CMD_TICK, 3'($urandom_range(0, 7)), $urandom);
                    else if (pick < 9)
                        queue_cmd(CMD_READ, 3'($urandom_range(0, 7)), $urandom);
                    else if ($urandom_range(0, 1) != 0)
                        queue_cmd(CMD_STOP, 3'($urandom_range(0, 7)), $urandom);
                    else
                        queue_cmd(CMD_START, 3'($urandom_range(0, 7)), $urandom);
                    queued++;
                end
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 3))
                    0: queue_cmd(CMD_CLEAR, 3'($urandom_range(0, 7)), $urandom);
                    1: queue_cmd(CMD_START, 3'($urandom_range(0, 7)), $urandom);
                    default: queue_cmd(CMD_READ, 3'($urandom_range(0, 7)), $urandom);
                endcase
                queued++;
            end
            else
            begin
                queue_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom);
                queued++;
            end
        end
    endtask

    // Hold off new commands until every queued one has reported back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_valid || status_due.size() != 0)
            @(posedge clk);
    endtask

    // Driver: predict on each transfer, then present the next command
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                status_due.push_back(apply_command(held_cmd));
            if (!cmd_valid || cmd_ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    held_cmd = cmd_backlog.pop_front();
                    cmd_valid    <= 1'b1;
                    cmd          <= held_cmd.op;
                    timer_index  <= held_cmd.idx;
                    reload_value <= held_cmd.value;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        timer_status_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_count));
                end
                else
                begin
                    want = status_due.pop_front();
                    if (elapsed_count !== want.elapsed)
                        report_mismatch($sformatf("result %0d elapsed_count 0x%0h, want 0x%0h",
                                                  result_count, elapsed_count, want.elapsed));
                    if (running !== want.running)
                        report_mismatch($sformatf("result %0d running %0b, want %0b",
                                                  result_count, running, want.running));
                    if (is_done !== want.done)
                        report_mismatch($sformatf("result %0d is_done %0b, want %0b",
                                                  result_count, is_done, want.done));
                    if (expired_mask !== want.fired)
                        report_mismatch($sformatf("result %0d expired_mask 0x%0h, want 0x%0h",
                                                  result_count, expired_mask, want.fired));
                end
                result_count++;
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int unsigned t;
        for (t = 0; t < TIMER_COUNT; t++)
        begin
            count_model[t]  = IDLE_MARK;
            reload_model[t] = 32'd0;
            run_model[t]    = 1'b0;
            done_model[t]   = 1'b0;
        end

        // Directed: idle status, a short expiry, zero and all-ones reloads,
        // stop and clear, spare opcodes, field extremes
        queue_cmd(CMD_READ, 3'd0, 32'd0);
        queue_cmd(CMD_LOAD, 3'd1, 32'd3);
        queue_cmd(CMD_START, 3'd1, 32'd0);
        queue_cmd(CMD_TICK, 3'd1, 32'd0);
        queue_cmd(CMD_TICK, 3'd1, IDLE_MARK);
        queue_cmd(CMD_TICK, 3'd1, 32'd0);
        queue_cmd(CMD_READ, 3'd1, 32'd0);
        queue_cmd(CMD_READ, 3'd1, 32'd0);
        queue_cmd(CMD_LOAD, 3'd2, 32'd0);
        queue_cmd(CMD_START, 3'd2, 32'd0);
        queue_cmd(CMD_LOAD, 3'd3, IDLE_MARK);
        queue_cmd(CMD_START, 3'd3, 32'd0);
        queue_cmd(CMD_TICK, 3'd2, 32'd0);
        queue_cmd(CMD_LOAD, 3'd7, 32'h0001_2345);
        queue_cmd(CMD_START, 3'd7, 32'd0);
        queue_cmd(CMD_TICK, 3'd7, 32'd0);
        queue_cmd(CMD_STOP, 3'd7, 32'd0);
        queue_cmd(CMD_CLEAR, 3'd7, 32'd0);
        queue_cmd(CMD_SPARE6, 3'd1, IDLE_MARK);
        queue_cmd(CMD_SPARE7, 3'd3, 32'd0);
        queue_cmd(CMD_CLEAR, 3'd1, IDLE_MARK);
        queue_cmd(CMD_LOAD, 3'd0, IDLE_MARK);
        queue_cmd(CMD_TICK, 3'd7, IDLE_MARK);

        // Phase one: light sender idling, heavy receiver stalls
        send_idle_pct = 15;
        recv_idle_pct = 68;
        queue_random_batch(610);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_drained();

        // Phase two: roles swapped
        send_idle_pct = 68;
        recv_idle_pct = 15;
        queue_random_batch(610);
        wait_drained();

        // Phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_batch(610);
        wait_drained();

        // Catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", status_due.size()));

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
